// ===== rtl/aoe_rc_pkg.sv =====
// aoe_rc_pkg: widths, codes and table sizing for the request classifier
// no dependencies; imported by aoe_request_classifier_top

package aoe_rc_pkg;

   // device table sizing
   localparam int MAX_DEVICES = 64;
   localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

   // field widths
   localparam int ENTRY_W     = 6;
   localparam int ETYPE_W     = 16;
   localparam int VERSION_W   = 4;
   localparam int SHELF_W     = 16;
   localparam int SLOT_W      = 8;
   localparam int FLEN_W      = 14;
   localparam int OUTCOME_W   = 2;
   localparam int PKT_W       = 32;
   localparam int BYTE_W      = 48;
   localparam int DEVCOUNT_W  = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // request commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_HEADER = 1'b1;

   // result outcomes
   localparam logic [OUTCOME_W-1:0] OUTCOME_DISPATCH = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_IGNORED  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_WRITTEN  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TYPE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION      = 2'd2;

   // reset values and broadcast addresses
   localparam logic [ETYPE_W-1:0]   FRAME_TYPE_RESET = 16'h88a2;
   localparam logic [VERSION_W-1:0] VERSION_RESET    = 4'd1;
   localparam logic [SHELF_W-1:0]   SHELF_BROADCAST  = 16'hffff;
   localparam logic [SLOT_W-1:0]    SLOT_BROADCAST   = 8'hff;

   // one device table entry
   typedef struct packed {
      logic [SHELF_W-1:0] shelf;
      logic [SLOT_W-1:0]  slot;
   } entry_type;

endpackage

// ===== rtl/aoe_request_classifier_top.sv =====
// aoe_request_classifier_top: device table, counters and dispatch sequencer
// depends on aoe_rc_pkg

// A request either writes one (shelf, slot) entry of the device table or
// classifies one received header. A table write, or a header that is ignored
// on ether type, version or response flag, goes from acceptance straight to
// the emit state and from there into the output register. A unicast header
// runs a binary search over the table held in one synchronous RAM, one probe
// per cycle, before the emit state. A broadcast header scans every valid entry
// (device_count clipped to 64), one RAM read per cycle while the result side
// does not stall.
// The next request is taken once the current one has queued its last result;
// a finished result waits in the output register meanwhile. All results of
// one header carry the counter values after that header. No clearing pass:
// table entries read before they are written return unknown data.

module aoe_request_classifier_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [aoe_rc_pkg::ENTRY_W-1:0]       req_entry_index,
   input  logic [aoe_rc_pkg::ETYPE_W-1:0]       req_frame_type,
   input  logic [aoe_rc_pkg::VERSION_W-1:0]     req_version,
   input  logic                                 req_resp_flag,
   input  logic [aoe_rc_pkg::SHELF_W-1:0]       req_shelf,
   input  logic [aoe_rc_pkg::SLOT_W-1:0]        req_slot,
   input  logic [aoe_rc_pkg::FLEN_W-1:0]        req_frame_length,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [aoe_rc_pkg::OUTCOME_W-1:0]     rsp_outcome,
   output logic [aoe_rc_pkg::ENTRY_W-1:0]       rsp_device_index,
   output logic                                 rsp_last,
   output logic [aoe_rc_pkg::PKT_W-1:0]         rsp_rx_packets,
   output logic [aoe_rc_pkg::BYTE_W-1:0]        rsp_rx_octets,
   output logic [aoe_rc_pkg::PKT_W-1:0]         rsp_ignored_packets,
   output logic [aoe_rc_pkg::PKT_W-1:0]         rsp_broadcast_packets,
   // configuration port
   input  logic                                 csr_write,
   input  logic [aoe_rc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aoe_rc_pkg::CSR_DATA_W-1:0]    csr_data
);

   import aoe_rc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // sequencer state
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       lo_ff, lo_in;
   logic [CNT_W-1:0]       hi_ff, hi_in;
   logic [IDX_W-1:0]       mid_ff, mid_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic                   have_pend_ff, have_pend_in;
   logic [OUTCOME_W-1:0]   pend_outcome_ff, pend_outcome_in;
   logic [IDX_W-1:0]       pend_index_ff, pend_index_in;
   logic [SHELF_W-1:0]     key_shelf_ff, key_shelf_in;
   logic [SLOT_W-1:0]      key_slot_ff, key_slot_in;

   // configuration registers
   logic [DEVCOUNT_W-1:0]  dev_count_ff, dev_count_in;
   logic [ETYPE_W-1:0]     frame_type_ff, frame_type_in;
   logic [VERSION_W-1:0]   version_ff, version_in;

   // counters
   logic [PKT_W-1:0]       pkt_cnt_ff, pkt_cnt_in;
   logic [BYTE_W-1:0]      byte_cnt_ff, byte_cnt_in;
   logic [PKT_W-1:0]       ign_cnt_ff, ign_cnt_in;
   logic [PKT_W-1:0]       bc_cnt_ff, bc_cnt_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic [ENTRY_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [PKT_W-1:0]       rsp_pkt_ff, rsp_pkt_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic [PKT_W-1:0]       rsp_ign_ff, rsp_ign_in;
   logic [PKT_W-1:0]       rsp_bc_ff, rsp_bc_in;

   // device table ram
   entry_type              table_mem [MAX_DEVICES];
   entry_type              rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;

   // working signals
   logic                   accept;
   logic                   can_emit;
   logic [CNT_W-1:0]       n_valid;
   logic                   hdr_bad;
   logic                   hdr_bcast;
   logic                   entry_oob;
   logic                   rd_less;
   logic                   rd_greater;
   logic                   rd_hit;
   logic [CNT_W-1:0]       srch_lo;
   logic [CNT_W-1:0]       srch_hi;
   logic [CNT_W:0]         srch_sum;
   logic [CNT_W-1:0]       scan_next;
   logic                   scan_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;

   // valid entries, clipped to the table depth
   assign n_valid = (dev_count_ff > DEVCOUNT_W'(MAX_DEVICES)) ? CNT_W'(MAX_DEVICES)
                                                              : CNT_W'(dev_count_ff);

   // header checks on the incoming request
   assign hdr_bad   = (req_frame_type != frame_type_ff) || (req_version != version_ff)
                      || req_resp_flag;
   assign hdr_bcast = (req_shelf == SHELF_BROADCAST) || (req_slot == SLOT_BROADCAST);
   assign entry_oob = (CNT_W'(req_entry_index) >= CNT_W'(MAX_DEVICES));
   assign wr_en     = accept && (req_cmd == CMD_WRITE) && !entry_oob;

   // compare of the entry read in the previous cycle
   assign rd_less    = (rd_data_ff.shelf < key_shelf_ff) ||
                       ((rd_data_ff.shelf == key_shelf_ff) && (rd_data_ff.slot < key_slot_ff));
   assign rd_greater = (rd_data_ff.shelf > key_shelf_ff) ||
                       ((rd_data_ff.shelf == key_shelf_ff) && (rd_data_ff.slot > key_slot_ff));
   assign rd_hit     = ((key_shelf_ff == SHELF_BROADCAST) || (rd_data_ff.shelf == key_shelf_ff))
                       && ((key_slot_ff == SLOT_BROADCAST) || (rd_data_ff.slot == key_slot_ff));

   // next search window and probe
   assign srch_lo  = rd_less ? (CNT_W'(mid_ff) + CNT_W'(1)) : lo_ff;
   assign srch_hi  = (!rd_less && rd_greater) ? CNT_W'(mid_ff) : hi_ff;
   assign srch_sum = {1'b0, srch_lo} + {1'b0, srch_hi};

   // scan position
   assign scan_next = CNT_W'(scan_ff) + CNT_W'(1);
   assign scan_end  = (scan_next == n_valid);

   // next-state and datapath logic
   always_comb begin
      state_in        = state_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      scan_in         = scan_ff;
      have_pend_in    = have_pend_ff;
      pend_outcome_in = pend_outcome_ff;
      pend_index_in   = pend_index_ff;
      key_shelf_in    = key_shelf_ff;
      key_slot_in     = key_slot_ff;
      dev_count_in    = dev_count_ff;
      frame_type_in   = frame_type_ff;
      version_in      = version_ff;
      pkt_cnt_in      = pkt_cnt_ff;
      byte_cnt_in     = byte_cnt_ff;
      ign_cnt_in      = ign_cnt_ff;
      bc_cnt_in       = bc_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_pkt_in      = rsp_pkt_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_ign_in      = rsp_ign_ff;
      rsp_bc_in       = rsp_bc_ff;
      rd_addr         = scan_ff;

      // configuration writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_DEVICE_COUNT: dev_count_in  = csr_data[DEVCOUNT_W-1:0];
            CSR_FRAME_TYPE:   frame_type_in = csr_data[ETYPE_W-1:0];
            CSR_VERSION:      version_in    = csr_data[VERSION_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (accept) begin
               key_shelf_in = req_shelf;
               key_slot_in  = req_slot;
               have_pend_in = 1'b0;
               state_in     = ST_EMIT;
               if (req_cmd == CMD_WRITE) begin
                  pend_outcome_in = entry_oob ? OUTCOME_IGNORED : OUTCOME_WRITTEN;
                  pend_index_in   = entry_oob ? '0 : req_entry_index[IDX_W-1:0];
               end else begin
                  pkt_cnt_in      = pkt_cnt_ff + PKT_W'(1);
                  byte_cnt_in     = byte_cnt_ff + BYTE_W'(req_frame_length);
                  pend_outcome_in = OUTCOME_IGNORED;
                  pend_index_in   = '0;
                  if (hdr_bad || (n_valid == '0)) begin
                     ign_cnt_in = ign_cnt_ff + PKT_W'(1);
                  end else if (hdr_bcast) begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end else begin
                     lo_in    = '0;
                     hi_in    = n_valid;
                     mid_in   = IDX_W'(n_valid >> 1);
                     rd_addr  = IDX_W'(n_valid >> 1);
                     state_in = ST_SEARCH;
                  end
               end
            end
         end

         // one binary search probe per cycle
         ST_SEARCH: begin
            if (!rd_less && !rd_greater) begin
               pend_outcome_in = OUTCOME_DISPATCH;
               pend_index_in   = mid_ff;
               state_in        = ST_EMIT;
            end else if (srch_lo < srch_hi) begin
               lo_in   = srch_lo;
               hi_in   = srch_hi;
               mid_in  = srch_sum[IDX_W:1];
               rd_addr = srch_sum[IDX_W:1];
            end else begin
               ign_cnt_in = ign_cnt_ff + PKT_W'(1);
               state_in   = ST_EMIT;
            end
         end

         // broadcast scan, one hit held back so the final one carries last
         ST_SCAN: begin
            if (rd_hit && have_pend_ff && !can_emit) begin
               rd_addr = scan_ff;
            end else begin
               if (rd_hit) begin
                  if (have_pend_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = OUTCOME_DISPATCH;
                     rsp_index_in   = ENTRY_W'(pend_index_ff);
                     rsp_last_in    = 1'b0;
                     rsp_pkt_in     = pkt_cnt_ff;
                     rsp_byte_in    = byte_cnt_ff;
                     rsp_ign_in     = ign_cnt_ff;
                     rsp_bc_in      = bc_cnt_ff;
                  end else begin
                     bc_cnt_in = bc_cnt_ff + PKT_W'(1);
                  end
                  have_pend_in    = 1'b1;
                  pend_outcome_in = OUTCOME_DISPATCH;
                  pend_index_in   = scan_ff;
               end
               if (scan_end) begin
                  have_pend_in = 1'b0;
                  state_in     = ST_EMIT;
                  if (!rd_hit && !have_pend_ff) begin
                     ign_cnt_in      = ign_cnt_ff + PKT_W'(1);
                     pend_outcome_in = OUTCOME_IGNORED;
                     pend_index_in   = '0;
                  end
               end else begin
                  scan_in = IDX_W'(scan_next);
                  rd_addr = IDX_W'(scan_next);
               end
            end
         end

         // final result of the request
         ST_EMIT: begin
            if (can_emit) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = pend_outcome_ff;
               rsp_index_in   = ENTRY_W'(pend_index_ff);
               rsp_last_in    = 1'b1;
               rsp_pkt_in     = pkt_cnt_ff;
               rsp_byte_in    = byte_cnt_ff;
               rsp_ign_in     = ign_cnt_ff;
               rsp_bc_in      = bc_cnt_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dev_count_ff  <= '0;
         frame_type_ff <= FRAME_TYPE_RESET;
         version_ff    <= VERSION_RESET;
         pkt_cnt_ff    <= '0;
         byte_cnt_ff   <= '0;
         ign_cnt_ff    <= '0;
         bc_cnt_ff     <= '0;
         lo_ff         <= '0;
         hi_ff         <= '0;
         mid_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         have_pend_ff  <= have_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         dev_count_ff  <= dev_count_in;
         frame_type_ff <= frame_type_in;
         version_ff    <= version_in;
         pkt_cnt_ff    <= pkt_cnt_in;
         byte_cnt_ff   <= byte_cnt_in;
         ign_cnt_ff    <= ign_cnt_in;
         bc_cnt_ff     <= bc_cnt_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         mid_ff        <= mid_in;
      end
      scan_ff         <= scan_in;
      pend_outcome_ff <= pend_outcome_in;
      pend_index_ff   <= pend_index_in;
      key_shelf_ff    <= key_shelf_in;
      key_slot_ff     <= key_slot_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_pkt_ff      <= rsp_pkt_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_ign_ff      <= rsp_ign_in;
      rsp_bc_ff       <= rsp_bc_in;
   end

   // device table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_entry_index[IDX_W-1:0]] <= '{shelf: req_shelf, slot: req_slot};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_outcome           = rsp_outcome_ff;
   assign rsp_device_index      = rsp_index_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_rx_packets        = rsp_pkt_ff;
   assign rsp_rx_octets         = rsp_byte_ff;
   assign rsp_ignored_packets   = rsp_ign_ff;
   assign rsp_broadcast_packets = rsp_bc_ff;

   // search window stays non-empty and the probe lies inside it
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((lo_ff < hi_ff) && (CNT_W'(mid_ff) >= lo_ff)
                                   && (CNT_W'(mid_ff) < hi_ff)))
      else $error("search probe outside window");

   // only broadcast dispatches are followed by further results
   a_nonlast_dispatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_outcome_ff == OUTCOME_DISPATCH))
      else $error("non-final result that is not a dispatch");

   // a held-back hit never survives past the scan
   a_pend_scoped: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> !have_pend_ff)
      else $error("pending hit outside broadcast scan");

   // a new result is loaded only when the output register has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && (state_ff == ST_EMIT)) |=> (state_ff == ST_EMIT))
      else $error("final result left while output was stalled");

endmodule
